@@ src/drbc_pkg.sv @@
// ----------------------------------------------------------------------------
// drbc_pkg: shared types and constants for the request bounds check unit
// Status codes, configuration and the item record passed along the cell row.
// ----------------------------------------------------------------------------
package drbc_pkg;

  localparam int DEVICE_BLOCK_SHIFT = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUO_W      = 33;   // dividend / quotient width
  localparam int DVS_W      = 31;   // sector size units times sectors per cylinder
  localparam int CHK_W      = 41;   // wide enough for shifted offsets plus length

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_END     = 2'd1,
    ST_INVALID = 2'd2,
    ST_RDONLY  = 2'd3
  } drbc_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_OFFSET   = 3'd0,
    REG_LABEL_OFFSET = 3'd1,
    REG_BLOCK_SHIFT  = 3'd2,
    REG_SECTOR_UNITS = 3'd3,
    REG_SPC          = 3'd4,
    REG_LABEL_WE     = 3'd5
  } drbc_reg_t;

  typedef struct packed {
    logic [31:0] raw_partition_offset;
    logic [7:0]  label_sector_offset;
    logic [2:0]  block_shift;
    logic [6:0]  sector_size_units;
    logic [23:0] sectors_per_cylinder;
    logic        label_write_enable;
  } drbc_cfg_t;

  typedef struct packed {
    drbc_status_t     status;
    logic [30:0]      byte_count;
    logic [30:0]      residual;
    logic [DVS_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DVS_W-1:0] dvs;
  } drbc_item_t;

endpackage

@@ src/drbc_if.sv @@
// ----------------------------------------------------------------------------
// drbc request / response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface drbc_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_block;
  logic [30:0]        byte_count;
  logic               is_read;
  logic [31:0]        part_size;
  logic [31:0]        part_offset;

  modport source (output valid, start_block, byte_count, is_read, part_size, part_offset,
                  input ready);
  modport sink   (input valid, start_block, byte_count, is_read, part_size, part_offset,
                  output ready);
endinterface

interface drbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [30:0] byte_count_out;
  logic [30:0] residual;
  logic [32:0] cylinder;

  modport source (output valid, status, byte_count_out, residual, cylinder, input ready);
  modport sink   (input valid, status, byte_count_out, residual, cylinder, output ready);
endinterface

@@ src/drbc_front.sv @@
// ----------------------------------------------------------------------------
// drbc_front: bounds and label checks
// Registers the status, truncated length and the dividend/divisor for the row.
// ----------------------------------------------------------------------------
module drbc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  drbc_pkg::drbc_cfg_t    cfg,
  drbc_req_if.sink               req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output drbc_pkg::drbc_item_t   out_item
);
  localparam int W  = drbc_pkg::CHK_W;
  localparam int DB = drbc_pkg::DEVICE_BLOCK_SHIFT;

  logic                 valid;
  drbc_pkg::drbc_item_t item, item_next;
  logic [W-1:0] blk, n, n2, psize, poff, label, first;
  logic [31:0]  nsum;
  logic [W-1:0] bc2_wide;
  logic         invalid0, over, at_end, beyond, ro;
  logic [30:0]  dvs_prod;

  assign req.ready = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_comb begin
    invalid0 = req.start_block[31] || (cfg.sector_size_units == '0) ||
               (cfg.sectors_per_cylinder == '0);
    blk   = W'(req.start_block[30:0]);
    psize = W'(req.part_size)   << cfg.block_shift;
    poff  = W'(req.part_offset) << cfg.block_shift;
    label = (W'(cfg.raw_partition_offset) + W'(cfg.label_sector_offset)) << cfg.block_shift;
    nsum  = {1'b0, req.byte_count} + 32'((1 << DB) - 1);
    n     = W'(nsum >> DB);
    over   = (blk + n) > psize;
    at_end = blk == psize;
    beyond = blk > psize;
    n2       = over ? (psize - blk) : n;
    bc2_wide = n2 << DB;
    first    = blk + poff;
    ro = (first <= label) && ((first + n2) > label) && !req.is_read &&
         !cfg.label_write_enable;
    dvs_prod = 31'(cfg.sector_size_units * cfg.sectors_per_cylinder);

    item_next.byte_count = req.byte_count;
    item_next.residual   = '0;
    item_next.rem        = '0;
    item_next.quo        = '0;
    item_next.dvs        = 31'd1;   // keeps the row's quotient at zero
    priority if (invalid0) begin
      item_next.status = drbc_pkg::ST_INVALID;
    end else if (over && at_end) begin
      item_next.status   = drbc_pkg::ST_END;
      item_next.residual = req.byte_count;
    end else if (over && beyond) begin
      item_next.status = drbc_pkg::ST_INVALID;
    end else begin
      if (over) item_next.byte_count = bc2_wide[30:0];
      if (ro) begin
        item_next.status = drbc_pkg::ST_RDONLY;
      end else begin
        item_next.status = drbc_pkg::ST_OK;
        item_next.quo    = 33'(req.start_block[30:0]) + 33'(req.part_offset);
        item_next.dvs    = dvs_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      item <= item_next;
    end
  end
endmodule

@@ src/drbc_div_cell.sv @@
// ----------------------------------------------------------------------------
// drbc_div_cell: one restoring division step
// Shifts one dividend bit into the remainder and one quotient bit out.
// ----------------------------------------------------------------------------
module drbc_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  drbc_pkg::drbc_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output drbc_pkg::drbc_item_t out_item
);
  logic                 valid;
  drbc_pkg::drbc_item_t item, item_next;
  logic [31:0]          rs, diff;
  logic                 ge;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_comb begin
    rs   = {in_item.rem, in_item.quo[32]};
    diff = rs - {1'b0, in_item.dvs};
    ge   = rs >= {1'b0, in_item.dvs};
    item_next     = in_item;
    item_next.rem = ge ? diff[30:0] : rs[30:0];
    item_next.quo = {in_item.quo[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end
endmodule

@@ src/disk_request_bounds_check_unit.sv @@
// Path: a request is registered in the check stage at transfer, then passes through
//   the 33 division cells; an output stall holds it in the row.
// Throughput: one request per cycle unless stalled; each cell holds one request.
// The 33-cell restoring divider row sets the latency.
// Reset (rst, synchronous): empties the row, loads register defaults.
// ----------------------------------------------------------------------------
// disk_request_bounds_check_unit: disk request partition bounds check
// Checks a transfer against its partition, truncates at the partition end,
// guards the label sector and computes the cylinder number.
// ----------------------------------------------------------------------------
module disk_request_bounds_check_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [drbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [drbc_pkg::CFG_DATA_W-1:0]       cfg_data,
  drbc_req_if.sink                              req,
  drbc_rsp_if.source                            rsp
);
  localparam int NCELL = drbc_pkg::QUO_W;

  drbc_pkg::drbc_cfg_t cfg;

  // Row of handshaked stages: index 0 is the check stage output, index k+1
  // the output of division cell k. Ready ripples back so bubbles collapse.
  logic [NCELL:0]       v;
  logic [NCELL:0]       r;
  drbc_pkg::drbc_item_t it [NCELL+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_partition_offset <= '0;
      cfg.label_sector_offset  <= '0;
      cfg.block_shift          <= '0;
      cfg.sector_size_units    <= 7'd1;
      cfg.sectors_per_cylinder <= 24'd1;
      cfg.label_write_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drbc_pkg::REG_RAW_OFFSET:   cfg.raw_partition_offset <= cfg_data;
        drbc_pkg::REG_LABEL_OFFSET: cfg.label_sector_offset  <= cfg_data[7:0];
        drbc_pkg::REG_BLOCK_SHIFT:  cfg.block_shift          <= cfg_data[2:0];
        drbc_pkg::REG_SECTOR_UNITS: cfg.sector_size_units    <= cfg_data[6:0];
        drbc_pkg::REG_SPC:          cfg.sectors_per_cylinder <= cfg_data[23:0];
        drbc_pkg::REG_LABEL_WE:     cfg.label_write_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Check stage: status, truncation, dividend and divisor
  drbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .out_valid (v[0]),
    .out_ready (r[0]),
    .out_item  (it[0])
  );

  // Cylinder = (start + part_offset) / (sector units * sectors per cylinder),
  // one quotient bit per cell, MSB first.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    drbc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[k]),
      .in_ready  (r[k]),
      .in_item   (it[k]),
      .out_valid (v[k+1]),
      .out_ready (r[k+1]),
      .out_item  (it[k+1])
    );
  end

  assign rsp.valid          = v[NCELL];
  assign r[NCELL]           = rsp.ready;
  assign rsp.status         = it[NCELL].status;
  assign rsp.byte_count_out = it[NCELL].byte_count;
  assign rsp.residual       = it[NCELL].residual;
  assign rsp.cylinder       = it[NCELL].quo;

`ifndef SYNTH
  // Only accepted requests carry a cylinder
  a_cyl_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != drbc_pkg::ST_OK) |-> rsp.cylinder == '0)
    else $error("cylinder nonzero on refused request");

  // Residual is the full length on end of partition, zero otherwise
  a_residual: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.status == drbc_pkg::ST_END) ?
                   (rsp.residual == rsp.byte_count_out) : (rsp.residual == '0)))
    else $error("residual inconsistent with status");

  // A stalled response stays in the last cell
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.cylinder))
    else $error("response lost while stalled");
`endif
endmodule

@@ dv/tb_disk_request_bounds_check_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_disk_request_bounds_check_unit: request bounds check testbench
// Directed table, then constrained-by-hand random requests over several
// register settings, with random idling on both channels. Every response is
// checked in order against a typed answer or a behavioral bounds/cylinder model.
// ----------------------------------------------------------------------------
module tb_disk_request_bounds_check_unit;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;     // pipeline depth plus margin
  localparam int RAND_PER_SET = 220;

  typedef struct {
    logic signed [31:0] start_block;
    logic [30:0]        byte_count;
    logic               is_read;
    logic [31:0]        part_size;
    logic [31:0]        part_offset;
  } disk_req_t;

  typedef struct {
    drbc_pkg::drbc_status_t status;
    logic [30:0]            byte_count;
    logic [30:0]            residual;
    logic [32:0]            cylinder;
  } disk_rsp_t;

  // directed row: request plus, where known by inspection, its response
  typedef struct {
    disk_req_t rq;
    bit        typed;
    disk_rsp_t rs;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [drbc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [drbc_pkg::CFG_DATA_W-1:0] cfg_data;

  drbc_req_if req ();
  drbc_rsp_if rsp ();

  disk_request_bounds_check_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  drbc_pkg::drbc_cfg_t regs;     // shadow of the register file
  disk_rsp_t   pending_rsp_q[$]; // responses owed, oldest first
  bit          typed_q[$];       // per offered request: typed answer given?
  disk_rsp_t   typed_rsp_q[$];
  int          err_cnt;
  int          cycles;
  int          tx_idle;          // sender idle percentage
  int          rx_idle;          // receiver idle percentage
  int          rx_hold;          // long receiver hold-off, in cycles

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Behavioral bounds check and cylinder calculation.
  function automatic disk_rsp_t calc_bounds(disk_req_t r, drbc_pkg::drbc_cfg_t c);
    logic [63:0] blk, nblk, psz, poff, lbl, first;
    disk_rsp_t   o;
    o.status     = drbc_pkg::ST_INVALID;
    o.byte_count = r.byte_count;
    o.residual   = '0;
    o.cylinder   = '0;
    if (r.start_block < 0 || c.sector_size_units == 0 || c.sectors_per_cylinder == 0)
      return o;
    blk  = 64'(unsigned'(r.start_block));
    psz  = 64'(r.part_size) << c.block_shift;
    poff = 64'(r.part_offset) << c.block_shift;
    lbl  = (64'(c.raw_partition_offset) + 64'(c.label_sector_offset)) << c.block_shift;
    nblk = (64'(r.byte_count) + (64'd1 << drbc_pkg::DEVICE_BLOCK_SHIFT) - 1)
           >> drbc_pkg::DEVICE_BLOCK_SHIFT;
    if (blk + nblk > psz) begin
      if (blk == psz) begin
        o.status   = drbc_pkg::ST_END;
        o.residual = r.byte_count;
        return o;
      end
      if (blk > psz) return o;
      nblk = psz - blk;
      o.byte_count = 31'(nblk << drbc_pkg::DEVICE_BLOCK_SHIFT);
    end
    first = blk + poff;
    if (first <= lbl && first + nblk > lbl && !r.is_read && !c.label_write_enable) begin
      o.status = drbc_pkg::ST_RDONLY;
      return o;
    end
    o.status   = drbc_pkg::ST_OK;
    o.cylinder = 33'((blk + 64'(r.part_offset)) / 64'(c.sector_size_units)
                     / 64'(c.sectors_per_cylinder));
    return o;
  endfunction

  // Cycle count and run timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Request side: on each transfer, queue the owed response.
  always @(posedge clk) begin
    disk_req_t r;
    if (!rst && req.valid && req.ready) begin
      r.start_block = req.start_block;
      r.byte_count  = req.byte_count;
      r.is_read     = req.is_read;
      r.part_size   = req.part_size;
      r.part_offset = req.part_offset;
      if (typed_q.pop_front()) pending_rsp_q.push_back(typed_rsp_q.pop_front());
      else                     pending_rsp_q.push_back(calc_bounds(r, regs));
    end
  end

  // Response side: compare each transfer against the oldest owed response.
  always @(posedge clk) begin
    disk_rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response with none outstanding");
        err_cnt++;
      end else begin
        e = pending_rsp_q.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status);
          err_cnt++;
        end
        if (rsp.byte_count_out !== e.byte_count) begin
          $error("byte_count_out exp %0d got %0d", e.byte_count, rsp.byte_count_out);
          err_cnt++;
        end
        if (rsp.residual !== e.residual) begin
          $error("residual exp %0d got %0d", e.residual, rsp.residual);
          err_cnt++;
        end
        if (rsp.cylinder !== e.cylinder) begin
          $error("cylinder exp %0d got %0d", e.cylinder, rsp.cylinder);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random ready, or a forced hold-off stretch.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rsp.ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic write_reg(drbc_pkg::drbc_reg_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      drbc_pkg::REG_RAW_OFFSET:   regs.raw_partition_offset = val;
      drbc_pkg::REG_LABEL_OFFSET: regs.label_sector_offset  = val[7:0];
      drbc_pkg::REG_BLOCK_SHIFT:  regs.block_shift          = val[2:0];
      drbc_pkg::REG_SECTOR_UNITS: regs.sector_size_units    = val[6:0];
      drbc_pkg::REG_SPC:          regs.sectors_per_cylinder = val[23:0];
      default:                    regs.label_write_enable   = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] raw, logic [7:0] lso, logic [2:0] shf,
                          logic [6:0] ssu, logic [23:0] spc, logic lwe);
    write_reg(drbc_pkg::REG_RAW_OFFSET, raw);
    write_reg(drbc_pkg::REG_LABEL_OFFSET, 32'(lso));
    write_reg(drbc_pkg::REG_BLOCK_SHIFT, 32'(shf));
    write_reg(drbc_pkg::REG_SECTOR_UNITS, 32'(ssu));
    write_reg(drbc_pkg::REG_SPC, 32'(spc));
    write_reg(drbc_pkg::REG_LABEL_WE, 32'(lwe));
  endtask

  // Wait for every owed response, then let the row empty out.
  task automatic drain;
    while (pending_rsp_q.size() != 0 || typed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offer one request; returns at the falling edge after its transfer.
  task automatic send_req(disk_req_t r, bit typed, disk_rsp_t rs);
    while ($urandom_range(99) < tx_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    typed_q.push_back(typed);
    if (typed) typed_rsp_q.push_back(rs);
    req.valid       <= 1'b1;
    req.start_block <= r.start_block;
    req.byte_count  <= r.byte_count;
    req.is_read     <= r.is_read;
    req.part_size   <= r.part_size;
    req.part_offset <= r.part_offset;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  function automatic logic [30:0] rand_count();
    case ($urandom_range(3))
      0:       return 31'($urandom_range(2048));
      1:       return 31'($urandom_range(64) << drbc_pkg::DEVICE_BLOCK_SHIFT)
                      + 31'($urandom_range(2)) - 31'd1;
      2:       return 31'($urandom_range(20000));
      default: return 31'($urandom);
    endcase
  endfunction

  // Random request, mostly aimed at the partition end or the label sector.
  function automatic disk_req_t rand_req();
    disk_req_t   r;
    logic [63:0] psz, lbl;
    r.byte_count  = rand_count();
    r.is_read     = $urandom_range(1);
    r.part_size   = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(4096));
    r.part_offset = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(100000));
    psz = 64'(r.part_size) << regs.block_shift;
    case ($urandom_range(9))
      0, 1, 2, 3: begin   // near the partition end
        if (psz < 64'h7FFF_FF00)
          r.start_block = 32'(psz) - 32'($urandom_range(40)) + 32'($urandom_range(2));
        else
          r.start_block = $urandom_range(32'h7FFF_FFFF);
        if (r.start_block < 0) r.start_block = 0;
      end
      4, 5, 6: begin      // around the label sector
        lbl = 64'(regs.raw_partition_offset) + 64'(regs.label_sector_offset);
        r.part_offset = (lbl > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                        : 32'(lbl) - 32'($urandom_range(3));
        if (lbl < 64'(r.part_offset)) r.part_offset = 32'(lbl);
        r.start_block = 32'((lbl - 64'(r.part_offset)) << regs.block_shift)
                        - 32'($urandom_range(3)) + 32'($urandom_range(2));
        if (r.start_block < 0) r.start_block = 0;
        r.part_size = $urandom;
        r.is_read   = ($urandom_range(3) == 0);
      end
      7:       r.start_block = $urandom_range(32'h7FFF_FFFF);
      default: begin      // noise over the whole field ranges
        r.start_block = $urandom;
        r.byte_count  = 31'($urandom);
        r.part_size   = $urandom;
        r.part_offset = $urandom;
      end
    endcase
    return r;
  endfunction

  task automatic rand_burst(int count, bit mid_pause);
    disk_rsp_t none;
    none = '{drbc_pkg::ST_OK, '0, '0, '0};
    for (int i = 0; i < count; i++) begin
      send_req(rand_req(), 1'b0, none);
      // sender waits for the row to empty once, halfway through
      if (mid_pause && i == count / 2) begin
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending_rsp_q.size() != 0) @(negedge clk);
      end
    end
    req.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Directed stimulus, run at reset register values (label at 0).
  dir_row_t dir_tab[] = '{
    '{'{-32'sd1, 31'h7FFF_FFFF, 1'b1, 32'd100, 32'd0}, 1'b1,
      '{drbc_pkg::ST_INVALID, 31'h7FFF_FFFF, 31'd0, 33'd0}},
    '{'{32'sh8000_0000, 31'd512, 1'b0, 32'hFFFF_FFFF, 32'd0}, 1'b1,
      '{drbc_pkg::ST_INVALID, 31'd512, 31'd0, 33'd0}},
    '{'{32'sd10, 31'd512, 1'b1, 32'd10, 32'd0}, 1'b1,
      '{drbc_pkg::ST_END, 31'd512, 31'd512, 33'd0}},
    '{'{32'sd10, 31'd0, 1'b1, 32'd10, 32'd0}, 1'b1,
      '{drbc_pkg::ST_OK, 31'd0, 31'd0, 33'd10}},
    '{'{32'sd11, 31'd1, 1'b1, 32'd10, 32'd0}, 1'b1,
      '{drbc_pkg::ST_INVALID, 31'd1, 31'd0, 33'd0}},
    '{'{32'sd5, 31'd4096, 1'b1, 32'd10, 32'd100}, 1'b1,
      '{drbc_pkg::ST_OK, 31'd2560, 31'd0, 33'd105}},
    '{'{32'sd0, 31'd512, 1'b0, 32'd100, 32'd0}, 1'b1,
      '{drbc_pkg::ST_RDONLY, 31'd512, 31'd0, 33'd0}},
    '{'{32'sd0, 31'd512, 1'b1, 32'd100, 32'd0}, 1'b1,
      '{drbc_pkg::ST_OK, 31'd512, 31'd0, 33'd0}},
    '{'{32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{drbc_pkg::ST_OK, 31'h7FFF_FFFF, 31'd0, 33'h1_7FFF_FFFE}},
    '{'{32'sd0, 31'd1, 1'b1, 32'd0, 32'd0}, 1'b1,
      '{drbc_pkg::ST_END, 31'd1, 31'd1, 33'd0}},
    '{'{32'sd0, 31'd0, 1'b0, 32'd0, 32'd0}, 1'b1,
      '{drbc_pkg::ST_OK, 31'd0, 31'd0, 33'd0}},
    '{'{32'sd0, 31'd513, 1'b0, 32'd1, 32'd5}, 1'b0,
      '{drbc_pkg::ST_OK, '0, '0, '0}},
    '{'{32'sd3, 31'd1000, 1'b0, 32'd4, 32'd0}, 1'b0,
      '{drbc_pkg::ST_OK, '0, '0, '0}},
    '{'{32'sd99, 31'd511, 1'b1, 32'd100, 32'd7}, 1'b0,
      '{drbc_pkg::ST_OK, '0, '0, '0}},
    '{'{32'sd0, 31'h7FFF_FE00, 1'b0, 32'hFFFF_FFFF, 32'd1}, 1'b0,
      '{drbc_pkg::ST_OK, '0, '0, '0}},
    '{'{32'sh7FFF_FFFF, 31'd0, 1'b0, 32'd0, 32'hFFFF_FFFF}, 1'b0,
      '{drbc_pkg::ST_OK, '0, '0, '0}}
  };

  initial begin
    // all inputs known from time zero
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = drbc_pkg::REG_RAW_OFFSET;
    cfg_data        = '0;
    req.valid       = 1'b0;
    req.start_block = '0;
    req.byte_count  = '0;
    req.is_read     = 1'b0;
    req.part_size   = '0;
    req.part_offset = '0;
    rsp.ready       = 1'b0;
    err_cnt         = 0;
    cycles          = 0;
    rx_hold         = 0;
    regs            = '{32'd0, 8'd0, 3'd0, 7'd1, 24'd1, 1'b0};
    // sender idles 31%, receiver 59% for the directed table and first three settings
    tx_idle = 31;
    rx_idle = 59;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rs);
    req.valid <= 1'b0;
    @(negedge clk);
    rand_burst(RAND_PER_SET, 1'b0);
    drain();

    // high extremes; receiver stalls long enough for the row to back up
    set_regs(32'hFFFF_FFFF, 8'd255, 3'd7, 7'd64, 24'hFF_FFFF, 1'b0);
    rx_hold = 300;
    rand_burst(RAND_PER_SET, 1'b0);
    drain();

    // label writes allowed, oversize sector units; sender pauses midway
    set_regs(32'd3, 8'd5, 3'd3, 7'd127, 24'd63, 1'b1);
    rand_burst(RAND_PER_SET, 1'b1);
    drain();

    // swap idling: sender 59%, receiver 31%
    tx_idle = 59;
    rx_idle = 31;
    set_regs(32'd1000, 8'd0, 3'd1, 7'd0, 24'd16, 1'b0);      // zero sector size
    rand_burst(RAND_PER_SET, 1'b0);
    drain();

    set_regs(32'd0, 8'd17, 3'd2, 7'd8, 24'd0, 1'b0);         // zero sectors/cylinder
    rand_burst(RAND_PER_SET, 1'b0);
    drain();

    // no idling for the rest
    tx_idle = 0;
    rx_idle = 0;
    set_regs($urandom_range(200000), 8'($urandom), 3'($urandom), 7'($urandom_range(1, 127)),
             24'($urandom_range(1, 24'hFF_FFFF)), 1'($urandom));
    rand_burst(RAND_PER_SET, 1'b0);
    drain();

    set_regs(32'd0, 8'd0, 3'd0, 7'd1, 24'd1, 1'b0);          // low extremes
    rand_burst(RAND_PER_SET, 1'b0);
    drain();

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
